/* sv/plee_pkg.sv */
// Shared types, constants and exponent table for the particle ease-out core.
package plee_pkg;

    localparam int ELAPSED_W  = 32;
    localparam int DELTA_W    = 20;
    localparam int SCALE_W    = 24;
    localparam int FRAC_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Exponent decay rate and table depth
    localparam int DECAY_RATE = 15;
    localparam int EXP_DEPTH  = 64;
    localparam int IDX_W      = $clog2(EXP_DEPTH);
    localparam int E_W        = FRAC_W + $clog2(DECAY_RATE + 1);
    localparam int SH_W       = E_W - 16;

    // Divider: one integer bit plus 16 fraction bits
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Product of the 25-bit scale span and the 17-bit ease weight
    localparam int DIFF_W = SCALE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LIFETIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_SCALE   = 2'd2;

    // round(65536 * 2^(-i/64))
    localparam logic [FRAC_W-1:0] EXP2_TABLE [EXP_DEPTH] = '{
        17'd65536, 17'd64830, 17'd64132, 17'd63441, 17'd62757, 17'd62081, 17'd61413, 17'd60751,
        17'd60097, 17'd59449, 17'd58809, 17'd58176, 17'd57549, 17'd56929, 17'd56316, 17'd55709,
        17'd55109, 17'd54515, 17'd53928, 17'd53347, 17'd52773, 17'd52204, 17'd51642, 17'd51085,
        17'd50535, 17'd49991, 17'd49452, 17'd48920, 17'd48393, 17'd47871, 17'd47356, 17'd46846,
        17'd46341, 17'd45842, 17'd45348, 17'd44859, 17'd44376, 17'd43898, 17'd43425, 17'd42958,
        17'd42495, 17'd42037, 17'd41584, 17'd41136, 17'd40693, 17'd40255, 17'd39821, 17'd39392,
        17'd38968, 17'd38548, 17'd38133, 17'd37722, 17'd37316, 17'd36914, 17'd36516, 17'd36123,
        17'd35734, 17'd35349, 17'd34968, 17'd34591, 17'd34219, 17'd33850, 17'd33486, 17'd33125
    };

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic update;
        logic div_step;
        logic exp_calc;
        logic mul_calc;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic destroy;
        logic div_last;
    } t_sts;

endpackage

/* sv/plee_ctrl.sv */
// Sequencing state machine and output valid for the particle ease-out core.
module plee_ctrl
    import plee_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (i_sts.destroy) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                    if (i_sts.div_last) begin
                        n_state = S_EXP;
                    end
                end
            end
            S_EXP: begin
                o_cmd.exp_calc = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_calc = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* sv/plee_dp.sv */
// Datapath: config registers, elapsed time, serial divider, exp2 lookup, multiply, output.
module plee_dp
    import plee_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [DELTA_W-1:0]     i_delta_time,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic                   o_destroy_request,
    output logic [SCALE_W-1:0]     o_scale,
    output logic [FRAC_W-1:0]      o_life_left_fraction
);

    // Configuration
    logic [ELAPSED_W-1:0] r_lifetime;
    logic [SCALE_W-1:0]   r_start;
    logic [SCALE_W-1:0]   r_end;

    // Working state
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [DELTA_W-1:0]   r_delta;
    logic                 r_destroy;
    logic [ELAPSED_W-1:0] r_rem;
    logic [FRAC_W-1:0]    r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [FRAC_W-1:0]    r_frac;
    logic [FRAC_W-1:0]    r_exp;
    logic [PROD_W-1:0]    r_prod;

    // Output register
    logic                 r_o_destroy;
    logic [SCALE_W-1:0]   r_o_scale;
    logic [FRAC_W-1:0]    r_o_life;

    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] sat;
    logic [ELAPSED_W:0]   trial;
    logic                 ge;
    logic [ELAPSED_W:0]   trial_sub;
    logic [FRAC_W-1:0]    frac;
    logic [E_W-1:0]       e_val;
    logic [IDX_W-1:0]     idx;
    logic [SH_W-1:0]      sh;
    logic signed [DIFF_W-1:0] diff;
    logic [FRAC_W-1:0]    weight;
    logic signed [PROD_W-1:0] prod;
    logic [SCALE_W+2:0]   sc_wide;

    // Saturating elapsed-time update
    assign sum = {1'b0, r_elapsed} + {{(ELAPSED_W + 1 - DELTA_W){1'b0}}, r_delta};
    assign sat = sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : sum[ELAPSED_W-1:0];

    // Restoring division: first step has no shift (integer bit)
    assign trial     = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign ge        = (trial >= {1'b0, r_lifetime});
    assign trial_sub = trial - {1'b0, r_lifetime};

    // Integer bit set means elapsed == lifetime (or zero lifetime): full life
    assign frac  = r_quo[FRAC_W-1] ? FRAC_ONE : r_quo;
    assign e_val = E_W'(frac) * E_W'(DECAY_RATE);
    assign idx   = e_val[15 -: IDX_W];
    assign sh    = e_val[E_W-1:16];

    assign diff   = $signed({r_end[SCALE_W-1], r_end}) - $signed({r_start[SCALE_W-1], r_start});
    assign weight = FRAC_ONE - r_exp;
    assign prod   = diff * $signed({1'b0, weight});

    // Floor division by 65536 is the arithmetic top slice of the product
    assign sc_wide = {{3{r_start[SCALE_W-1]}}, r_start} + r_prod[PROD_W-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= ELAPSED_W'(32'h0001_0000);
            r_start    <= SCALE_W'(24'h01_0000);
            r_end      <= '0;
            r_elapsed  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_LIFETIME:    r_lifetime <= i_cfg_wdata;
                    REG_START_SCALE: r_start    <= i_cfg_wdata[SCALE_W-1:0];
                    REG_END_SCALE:   r_end      <= i_cfg_wdata[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.update) begin
                r_elapsed <= sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_delta <= i_delta_time;
        end
        if (i_cmd.update) begin
            r_destroy <= (sat > r_lifetime);
            r_rem     <= sat;
            r_cnt     <= '0;
            r_quo     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? trial_sub[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
            r_quo <= {r_quo[FRAC_W-2:0], ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.exp_calc) begin
            r_frac <= frac;
            r_exp  <= EXP2_TABLE[idx] >> sh;
        end
        if (i_cmd.mul_calc) begin
            r_prod <= prod;
        end
        if (i_cmd.out_load) begin
            r_o_destroy <= r_destroy;
            r_o_scale   <= r_destroy ? '0 : sc_wide[SCALE_W-1:0];
            r_o_life    <= r_destroy ? '0 : (FRAC_ONE - r_frac);
        end
    end

    assign o_sts.destroy  = r_destroy;
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    assign o_destroy_request    = r_o_destroy;
    assign o_scale              = r_o_scale;
    assign o_life_left_fraction = r_o_life;

endmodule

/* sv/particle_life_ease_out_core.sv */
// Top level of the particle lifetime and exponential ease-out scale core.
//
// Each accepted delta_time transaction advances a saturating Q16.16 elapsed
// time and yields exactly one result transaction. When the elapsed time is
// beyond the lifetime, the result carries destroy_request = 1 with zero scale
// and zero life-left fraction; the particle stays destroyed on every later
// tick until reset or until a lifetime at or above the elapsed time is
// written. Otherwise the lived fraction elapsed/lifetime (Q1.16) comes
// from a restoring divider that resolves one quotient bit per cycle, the
// factor 2^(-15*frac) is read from a 64-entry exp2 table and shifted, and one
// 25x18 multiply eases the scale from start_scale toward end_scale.
// On the normal path an accepted input runs through the update, 17 divider
// steps, table lookup, multiply and output load; a destroy skips the divider
// steps, lookup and multiply, and the output load waits for a free output
// register. One transaction is in flight at a time: no new input is accepted
// until the result is loaded. A finished result sits in an output register,
// and the next input is accepted while it waits to be taken. Configuration
// registers (0 lifetime, 1 start_scale, 2 end_scale) are written through a
// plain write port; the user must write them only when the core is idle, as
// the core does not enforce it. Writes to index 3 are ignored.
module particle_life_ease_out_core
    import plee_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // tick input
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [DELTA_W-1:0]    i_delta_time,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_destroy_request,
    output logic [SCALE_W-1:0]    o_scale,
    output logic [FRAC_W-1:0]     o_life_left_fraction
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer: decides which datapath step runs each cycle
    plee_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic, configuration and result registers
    plee_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_delta_time         (i_delta_time),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .o_destroy_request    (o_destroy_request),
        .o_scale              (o_scale),
        .o_life_left_fraction (o_life_left_fraction)
    );

endmodule

/* sv/plee_checker.sv */
// Port-level checks for the particle ease-out core, bound to the top level.
module plee_checker
    import plee_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_destroy_request,
    input logic [SCALE_W-1:0] o_scale,
    input logic [FRAC_W-1:0]  o_life_left_fraction
);

    // A pending result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before acceptance");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_destroy_request) && $stable(o_scale) && $stable(o_life_left_fraction))
        else $error("result payload changed while stalled");

    // Destroyed particle reports zero scale and zero life left
    a_destroy_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_destroy_request |-> (o_scale == '0) && (o_life_left_fraction == '0))
        else $error("destroy result with nonzero payload");

    // Life-left fraction never exceeds one
    a_life_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_life_left_fraction[FRAC_W-1] |-> (o_life_left_fraction[FRAC_W-2:0] == '0))
        else $error("life-left fraction above one");

    // One transaction in flight: input closes right after an acceptance
    a_in_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted again while busy");

endmodule

bind particle_life_ease_out_core plee_checker u_plee_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_ready           (o_in_ready),
    .o_out_valid          (o_out_valid),
    .i_out_ready          (i_out_ready),
    .o_destroy_request    (o_destroy_request),
    .o_scale              (o_scale),
    .o_life_left_fraction (o_life_left_fraction)
);

/* dv/tb.sv */
// Self-checking testbench for the particle lifetime and ease-out scale core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plee_pkg::*;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int RANDOM_ITEMS = 1600;
    // Worst gap between handshakes is the core's work on one tick plus a
    // long receiver stall and a sender gap; the limit is many times that.
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 40;   // margin well beyond the core latency
    localparam int SETTLE       = 2;    // quiet cycles before a register write

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // decodes to nothing
    localparam logic [DELTA_W-1:0]   DELTA_MAX  = '1;
    // Past this the next full-size tick reaches or clamps at all ones.
    localparam logic [ELAPSED_W-1:0] RAMP_TOP   = 32'hFFF0_0000;

    // round(65536 * 2^(-i/64)), kept apart from the RTL's own copy
    localparam logic [FRAC_W-1:0] EXP2_STEPS [64] = '{
        17'd65536, 17'd64830, 17'd64132, 17'd63441, 17'd62757, 17'd62081, 17'd61413, 17'd60751,
        17'd60097, 17'd59449, 17'd58809, 17'd58176, 17'd57549, 17'd56929, 17'd56316, 17'd55709,
        17'd55109, 17'd54515, 17'd53928, 17'd53347, 17'd52773, 17'd52204, 17'd51642, 17'd51085,
        17'd50535, 17'd49991, 17'd49452, 17'd48920, 17'd48393, 17'd47871, 17'd47356, 17'd46846,
        17'd46341, 17'd45842, 17'd45348, 17'd44859, 17'd44376, 17'd43898, 17'd43425, 17'd42958,
        17'd42495, 17'd42037, 17'd41584, 17'd41136, 17'd40693, 17'd40255, 17'd39821, 17'd39392,
        17'd38968, 17'd38548, 17'd38133, 17'd37722, 17'd37316, 17'd36914, 17'd36516, 17'd36123,
        17'd35734, 17'd35349, 17'd34968, 17'd34591, 17'd34219, 17'd33850, 17'd33486, 17'd33125
    };

    // One result transaction as the core presents it
    typedef struct packed {
        logic                destroy;
        logic [SCALE_W-1:0]  scale;
        logic [FRAC_W-1:0]   left_frac;
    } ease_result_t;

    // Directed plan: register writes, single ticks, and the saturation ramp
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TICK,
        ROW_RAMP
    } row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [DELTA_W-1:0]     delta;
        logic                   pinned;   // want holds a hand-typed result
        ease_result_t           want;
    } stim_row_t;

    localparam ease_result_t GONE = '{1'b1, '0, '0};

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        return '{ROW_CFG, idx, data, '0, 1'b0, '0};
    endfunction

    function automatic stim_row_t tick_row(input logic [DELTA_W-1:0] delta);
        return '{ROW_TICK, '0, '0, delta, 1'b0, '0};
    endfunction

    function automatic stim_row_t pinned_row(input logic [DELTA_W-1:0] delta,
                                             input ease_result_t want);
        return '{ROW_TICK, '0, '0, delta, 1'b1, want};
    endfunction

    // Rows [0, HEAD_LEN) run right after reset. The rest run after the random
    // part: elapsed time never goes back, so saturating it has to come last.
    localparam int HEAD_LEN = 23;
    localparam int PLAN_LEN = 30;
    localparam stim_row_t PLAN [PLAN_LEN] = '{
        // reset values: lifetime 1.0 s, start 1.0, elapsed 0 -> full start scale
        pinned_row(20'h0, '{1'b0, 24'h010000, 17'h10000}),
        // zero lifetime at elapsed 0: not destroyed, taken as fully lived
        cfg_row(REG_LIFETIME, 32'h0),
        tick_row(20'h0),
        // smallest lifetime, elapsed lands exactly on it -> frac exactly one
        cfg_row(REG_LIFETIME, 32'h1),
        tick_row(20'h1),
        // zero lifetime with elapsed 1 destroys, and keeps destroying
        cfg_row(REG_LIFETIME, 32'h0),
        pinned_row(20'h0, GONE),
        pinned_row(20'h0, GONE),
        // write to the unused index must not reach lifetime
        cfg_row(REG_UNUSED, 32'h1),
        pinned_row(20'h0, GONE),
        // widest lifetime, scale extremes with junk in the upper data bits
        cfg_row(REG_LIFETIME, 32'hFFFF_FFFF),
        cfg_row(REG_START_SCALE, 32'hFF7F_FFFF),
        cfg_row(REG_END_SCALE, 32'h0080_0000),
        pinned_row(20'h0, '{1'b0, 24'h7FFFFF, 17'h10000}),
        tick_row(DELTA_MAX),
        // swap the scale extremes, then walk frac from one half to past one
        cfg_row(REG_START_SCALE, 32'h0080_0000),
        cfg_row(REG_END_SCALE, 32'hFF7F_FFFF),
        cfg_row(REG_LIFETIME, 32'h0020_0000),
        tick_row(20'h0),
        tick_row(20'hAAAAA),
        tick_row(20'h55555),
        tick_row(20'h1),
        pinned_row(20'h1, GONE),
        // ---- tail: elapsed-time saturation ----
        cfg_row(REG_LIFETIME, 32'h0),          // ramp runs on the short destroy path
        '{ROW_RAMP, '0, '0, '0, 1'b0, '0},
        cfg_row(REG_LIFETIME, 32'hFFFF_FFFF),
        tick_row(DELTA_MAX),                   // clamps, must not wrap
        tick_row(DELTA_MAX),
        cfg_row(REG_LIFETIME, 32'hFFFF_FFFE),
        pinned_row(20'h0, GONE)
    };

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [DELTA_W-1:0]    i_delta_time = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_destroy_request;
    logic [SCALE_W-1:0]    o_scale;
    logic [FRAC_W-1:0]     o_life_left_fraction;

    always #5 i_clk = ~i_clk;

    particle_life_ease_out_core DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_delta_time         (i_delta_time),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_destroy_request    (o_destroy_request),
        .o_scale              (o_scale),
        .o_life_left_fraction (o_life_left_fraction)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirrors the core's registers and elapsed time
    // ------------------------------------------------------------------
    logic [ELAPSED_W-1:0] life_cfg     = 32'h0001_0000;
    logic [SCALE_W-1:0]   start_cfg    = 24'h010000;
    logic [SCALE_W-1:0]   end_cfg      = 24'h000000;
    logic [ELAPSED_W-1:0] life_elapsed = '0;

    ease_result_t due_results [$];   // eased results the core still owes
    ease_result_t pin_result;
    bit           pin_armed = 1'b0;

    int send_idle = 30;   // percent of cycles the sender holds back
    int recv_idle = 62;   // percent of cycles the receiver stalls
    int n_fail = 0;
    int ticks_taken = 0;
    int results_seen = 0;
    int destroys_seen = 0;
    int reg_writes = 0;

    // Advance elapsed time by one tick and work out the core's answer.
    function automatic ease_result_t ease_step(input logic [DELTA_W-1:0] delta);
        logic [ELAPSED_W:0] sum;
        longint unsigned    frac, expo, idx, shift, weight;
        longint             s0, s1, prod;
        ease_result_t       res;
        sum = {1'b0, life_elapsed} + delta;
        life_elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
        res = '0;
        if (life_elapsed > life_cfg) begin
            res.destroy = 1'b1;
            return res;
        end
        // lived fraction in Q1.16; zero lifetime counts as fully lived
        if (life_cfg == '0) begin
            frac = 65536;
        end else begin
            frac = (64'(life_elapsed) << 16) / 64'(life_cfg);
        end
        if (frac > 65536) begin
            frac = 65536;
        end
        // 2^(-DECAY_RATE*frac): table on the fraction bits, shift on the integer part
        expo   = DECAY_RATE * frac;
        idx    = ((expo & 64'hFFFF) * EXP_DEPTH) >> 16;
        shift  = expo >> 16;
        weight = (shift >= 32) ? 0 : (64'(EXP2_STEPS[idx]) >> shift);
        s0     = longint'($signed(start_cfg));
        s1     = longint'($signed(end_cfg));
        prod   = (s1 - s0) * longint'(65536 - weight);
        res.scale     = SCALE_W'(s0 + (prod >>> 16));   // floor toward minus infinity
        res.left_frac = FRAC_W'(65536 - frac);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitors: sample handshakes at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : handshake_mon
        ease_result_t want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                want = ease_step(i_delta_time);
                if (pin_armed) begin
                    want = pin_result;
                    pin_armed = 1'b0;
                end
                due_results.push_back(want);
                ticks_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (o_destroy_request) begin
                    destroys_seen++;
                end
                if (due_results.size() == 0) begin
                    $error("result transaction with no tick awaiting it");
                    n_fail++;
                end else begin
                    want = due_results.pop_front();
                    if (o_destroy_request !== want.destroy) begin
                        $error("destroy_request: expected %0d, actual %0d",
                               want.destroy, o_destroy_request);
                        n_fail++;
                    end
                    if (o_scale !== want.scale) begin
                        $error("scale: expected %0d, actual %0d",
                               $signed(want.scale), $signed(o_scale));
                        n_fail++;
                    end
                    if (o_life_left_fraction !== want.left_frac) begin
                        $error("life_left_fraction: expected %0d, actual %0d",
                               want.left_frac, o_life_left_fraction);
                        n_fail++;
                    end
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Watchdog: too long without any transaction or register write
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers: all start and end on a falling edge
    // ------------------------------------------------------------------
    // Offer one tick, with random idle cycles first; returns once accepted.
    // Valid is left high so a back-to-back tick keeps it up.
    task automatic send_tick(input logic [DELTA_W-1:0] delta);
        int seen;
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_delta_time <= delta;
        seen = ticks_taken;
        do @(negedge i_clk); while (ticks_taken == seen);
    endtask

    // Register write, only once the core has delivered everything it owes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        reg_writes++;
        case (idx)
            REG_LIFETIME:    life_cfg  = data;
            REG_START_SCALE: start_cfg = data[SCALE_W-1:0];
            REG_END_SCALE:   end_cfg   = data[SCALE_W-1:0];
            default: ;  // ignored by the core
        endcase
    endtask

    task automatic walk_rows(input int lo, input int hi);
        stim_row_t row;
        for (int i = lo; i < hi; i++) begin
            row = PLAN[i];
            case (row.kind)
                ROW_CFG: write_reg(row.reg_idx, row.wdata);
                ROW_TICK: begin
                    pin_armed  = row.pinned;
                    pin_result = row.want;
                    send_tick(row.delta);
                end
                default: begin
                    while (life_elapsed < RAMP_TOP) send_tick(DELTA_MAX);
                end
            endcase
        end
    endtask

    // Scale word: extremes or zero some of the time, random junk above bit 23.
    function automatic logic [CFG_DATA_W-1:0] scale_word();
        logic [SCALE_W-1:0] v;
        logic [7:0]         junk;
        junk = 8'($urandom());
        case ($urandom_range(0, 7))
            0:       v = 24'h800000;
            1:       v = 24'h7FFFFF;
            2:       v = '0;
            default: v = SCALE_W'($urandom());
        endcase
        return {junk, v};
    endfunction

    // Random particle lives: pick a lifetime a random span past the current
    // elapsed time (now and then any 32-bit value), fresh start and end
    // scales, then a burst of ticks sized so the burst usually sweeps frac
    // upward and runs past the lifetime into destroys.
    task automatic random_lives(input int quota);
        int                  sent;
        int                  k;
        int                  n;
        int                  r;
        longint unsigned     span;
        longint unsigned     reach;
        longint unsigned     step;
        logic [ELAPSED_W-1:0] life;
        logic [DELTA_W-1:0]  d;
        sent = 0;
        while (sent < quota) begin
            k    = $urandom_range(0, 24);
            span = (64'($urandom()) & ((64'd1 << k) - 1)) + 1;
            if ($urandom_range(0, 7) == 0) begin
                life = $urandom();
            end else begin
                reach = 64'(life_elapsed) + span;
                life  = (reach > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : reach[31:0];
            end
            write_reg(REG_LIFETIME, life);
            write_reg(REG_START_SCALE, scale_word());
            write_reg(REG_END_SCALE, scale_word());
            n    = $urandom_range(4, 20);
            step = span * 2 / n + 1;
            if (step > 64'(DELTA_MAX)) begin
                step = 64'(DELTA_MAX);
            end
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    d = DELTA_W'($urandom());        // any delta, all bits
                end else if (r < 12) begin
                    d = '0;
                end else begin
                    d = DELTA_W'($urandom_range(0, int'(step)));
                end
                send_tick(d);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender light idling, receiver heavy stalls
        walk_rows(0, HEAD_LEN);
        random_lives(RANDOM_ITEMS / 3);

        // roles swapped
        send_idle = 62;
        recv_idle = 30;
        random_lives(RANDOM_ITEMS / 3);

        // full throughput, then the saturation tail
        send_idle = 0;
        recv_idle = 0;
        random_lives(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        walk_rows(HEAD_LEN, PLAN_LEN);

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d ticks (%0d destroys) and %0d register writes,",
                 ticks_taken, destroys_seen, reg_writes);
        $display("under three idle/stall mixes, ending with elapsed time saturated.");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
